[hdl/mts_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the timer scheduler.
// No dependencies; the cell, the top level and the testbench reference it by scoped names.
package mts_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_REG    = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_REG_OK  = 3'd0,
    KIND_REG_REJ = 3'd1,
    KIND_CANCEL  = 3'd2,
    KIND_EXPIRY  = 3'd3,
    KIND_DONE    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Broadcast to every slot cell; wr/clr selects are per cell.
  typedef struct packed {
    logic        tick;
    logic [31:0] period;
    logic        mode;
    logic [31:0] tag;
  } cell_cmd_t;

  // Expiry offered by the cell that holds the scan token.
  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic        mode;
  } expiry_t;

endpackage

[hdl/mts_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on nothing but plain logic types.
interface mts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  timer_slot;
  logic [31:0] period_ticks;
  logic        repeat_mode;
  logic [31:0] arg_tag;

  modport source (output valid, operation, timer_slot, period_ticks, repeat_mode, arg_tag,
                  input ready);
  modport sink   (input valid, operation, timer_slot, period_ticks, repeat_mode, arg_tag,
                  output ready);
endinterface

interface mts_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [3:0]  fired_slot;
  logic [31:0] fired_tag;
  logic [63:0] tick_time;
  logic        fired_mode;
  logic        last;

  modport source (output valid, result_kind, fired_slot, fired_tag, tick_time, fired_mode,
                  last, input ready);
  modport sink   (input valid, result_kind, fired_slot, fired_tag, tick_time, fired_mode,
                  last, output ready);
endinterface

[hdl/mts_cell.sv]
`timescale 1ns / 1ps
// One timer slot: period, elapsed count, tag, mode, and a pending-expiry flag.
// Uses mts_pkg; passes the scan token to its upper neighbor.
module mts_cell #(
  parameter logic [3:0] SLOT_ID = 4'd0
) (
  input  logic               clk,
  input  logic               rst,
  input  mts_pkg::cell_cmd_t cmd,
  input  logic               wr_sel,
  input  logic               clr_sel,
  input  logic               token_in,
  input  logic               out_free,
  output logic               token_out,
  output mts_pkg::expiry_t   exp
);

  logic        active;
  logic        repeat_on;
  logic [31:0] period;
  logic [31:0] elapsed;
  logic [31:0] tag;
  logic        pend;
  logic        token;
  logic [31:0] elapsed_inc;
  logic        due;
  logic        emit;

  assign elapsed_inc = (elapsed < period) ? elapsed + 32'd1 : elapsed;
  assign due         = active && (elapsed_inc >= period);
  assign emit        = token && pend && out_free;
  assign token_out   = token && (!pend || out_free);

  always_comb begin
    exp.hit  = emit;
    exp.slot = emit ? SLOT_ID : 4'd0;
    exp.tag  = emit ? tag : 32'd0;
    exp.mode = emit ? repeat_on : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend   <= 1'b0;
      token  <= 1'b0;
    end else begin
      token <= token_in || (token && !token_out);
      if (emit) pend <= 1'b0;
      if (cmd.tick && active) begin
        if (due) begin
          pend <= 1'b1;
          // restart a repeating slot, free a one-shot one
          if (repeat_on) elapsed <= 32'd0;
          else begin
            active  <= 1'b0;
            elapsed <= elapsed_inc;
          end
        end else begin
          elapsed <= elapsed_inc;
        end
      end
      if (wr_sel) begin
        active    <= 1'b1;
        repeat_on <= cmd.mode;
        period    <= cmd.period;
        elapsed   <= 32'd0;
        tag       <= cmd.tag;
      end else if (clr_sel) begin
        active <= 1'b0;
      end
    end
  end

endmodule

[hdl/multi_timer_scheduler_unit.sv]
`timescale 1ns / 1ps
// Timer scheduler top level: request decode, slot cell chain, result register.
// Depends on mts_pkg, mts_if and mts_cell.
//
// Usage: requests arrive on req (tick, register, cancel), results leave on rsp.
// Register and cancel give one result, loaded into the output register at the
// accepting edge, so it shows in the next cycle. A tick updates every active slot at
// the accepting edge, then a scan token walks the slot cells from slot 0 upward,
// one cell per cycle while the receiver is free; a cell with a pending expiry
// emits it as the token passes. After the last cell a done result (last = 1)
// closes the tick. The block takes one request at a time: req.ready is high
// only when idle and the output register can load. When the receiver stalls,
// the token holds at the emitting cell and the result register holds its
// value. Reset clears all slots, the tick count and the output valid flag; no
// clearing pass is needed.
module multi_timer_scheduler_unit #(
  parameter int NUM_TIMERS = 16
) (
  input  logic       clk,
  input  logic       rst,
  mts_req_if.sink    req,
  mts_rsp_if.source  rsp
);

  mts_pkg::state_t    state;
  mts_pkg::state_t    state_next;
  mts_pkg::cell_cmd_t cmd;
  mts_pkg::expiry_t   cell_exp [NUM_TIMERS];
  mts_pkg::expiry_t   exp_any;
  logic [63:0]        global_ticks;
  logic [NUM_TIMERS-1:0] pass;
  logic [NUM_TIMERS-1:0] wr_sel;
  logic [NUM_TIMERS-1:0] clr_sel;
  logic               out_free;
  logic               accept;
  logic               reject;
  mts_pkg::op_t       op;

  assign op       = mts_pkg::op_t'(req.operation);
  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == mts_pkg::ST_IDLE) && out_free;
  assign accept   = req.valid && req.ready;
  assign reject   = (req.period_ticks == 32'd0) ||
                    ({28'd0, req.timer_slot} >= 32'(NUM_TIMERS));

  always_comb begin
    cmd.tick   = accept && (op == mts_pkg::OP_TICK);
    cmd.period = req.period_ticks;
    cmd.mode   = req.repeat_mode;
    cmd.tag    = req.arg_tag;
  end

  genvar g;
  generate
    for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
      logic hit_slot;
      logic tok_in;
      assign hit_slot   = (7'(req.timer_slot) == 7'(g));
      assign wr_sel[g]  = accept && (op == mts_pkg::OP_REG) && !reject && hit_slot;
      assign clr_sel[g] = accept && (op == mts_pkg::OP_CANCEL) && hit_slot;
      if (g == 0) begin : g_head
        assign tok_in = cmd.tick;
      end else begin : g_link
        assign tok_in = pass[g-1];
      end
      mts_cell #(
        .SLOT_ID (4'(g))
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .wr_sel    (wr_sel[g]),
        .clr_sel   (clr_sel[g]),
        .token_in  (tok_in),
        .out_free  (out_free),
        .token_out (pass[g]),
        .exp       (cell_exp[g])
      );
    end
  endgenerate

  // only the token holder drives a nonzero expiry
  always_comb begin
    exp_any = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      exp_any = exp_any | cell_exp[i];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mts_pkg::ST_IDLE: if (cmd.tick) state_next = mts_pkg::ST_SCAN;
      mts_pkg::ST_SCAN: if (pass[NUM_TIMERS-1]) state_next = mts_pkg::ST_DONE;
      mts_pkg::ST_DONE: if (out_free) state_next = mts_pkg::ST_IDLE;
      default:          state_next = mts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mts_pkg::ST_IDLE;
      global_ticks <= 64'd0;
    end else begin
      state <= state_next;
      if (cmd.tick) global_ticks <= global_ticks + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept && (op == mts_pkg::OP_REG || op == mts_pkg::OP_CANCEL)) begin
      rsp.valid       <= 1'b1;
      rsp.result_kind <= (op == mts_pkg::OP_CANCEL) ? mts_pkg::KIND_CANCEL :
                         reject ? mts_pkg::KIND_REG_REJ : mts_pkg::KIND_REG_OK;
      rsp.fired_slot  <= req.timer_slot;
      rsp.fired_tag   <= 32'd0;
      rsp.tick_time   <= global_ticks;
      rsp.fired_mode  <= 1'b0;
      rsp.last        <= 1'b1;
    end else if (state == mts_pkg::ST_SCAN && exp_any.hit) begin
      rsp.valid       <= 1'b1;
      rsp.result_kind <= mts_pkg::KIND_EXPIRY;
      rsp.fired_slot  <= exp_any.slot;
      rsp.fired_tag   <= exp_any.tag;
      rsp.tick_time   <= global_ticks;
      rsp.fired_mode  <= exp_any.mode;
      rsp.last        <= 1'b0;
    end else if (state == mts_pkg::ST_DONE && out_free) begin
      rsp.valid       <= 1'b1;
      rsp.result_kind <= mts_pkg::KIND_DONE;
      rsp.fired_slot  <= 4'd0;
      rsp.fired_tag   <= 32'd0;
      rsp.tick_time   <= global_ticks;
      rsp.fired_mode  <= 1'b0;
      rsp.last        <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

endmodule

[sim/tb_multi_timer_scheduler_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for multi_timer_scheduler_unit: directed table, then random traffic.
// Depends on mts_pkg, mts_if and the scheduler RTL; results are checked against a local model.
module tb_multi_timer_scheduler_unit;

  localparam int SLOT_COUNT   = 16;
  localparam int RANDOM_ITEMS = 300;
  localparam int HOLD_AT      = 140;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = SLOT_COUNT + 20;
  localparam int IDLE_LIMIT   = 3000;

  typedef struct {
    mts_pkg::op_t op;
    logic [3:0]   slot;
    logic [31:0]  period;
    logic         mode;
    logic [31:0]  tag;
  } request_t;

  typedef struct {
    mts_pkg::kind_t kind;
    logic [3:0]     slot;
    logic [31:0]    tag;
    logic [63:0]    ticks;
    logic           mode;
    logic           last;
  } result_t;

  typedef struct {
    request_t rq;
    bit       typed;
    result_t  typed_result;
  } stimulus_row_t;

  logic clk = 1'b0;
  logic rst;

  mts_req_if req_ch ();
  mts_rsp_if rsp_ch ();

  multi_timer_scheduler_unit #(
    .NUM_TIMERS(SLOT_COUNT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timer table as the scheduler should hold it
  logic [63:0] ticks_now;
  logic        armed     [SLOT_COUNT];
  logic        repeating [SLOT_COUNT];
  logic [31:0] period_of [SLOT_COUNT];
  logic [31:0] elapsed_of[SLOT_COUNT];
  logic [31:0] tag_of    [SLOT_COUNT];

  result_t       expected_results[$];
  stimulus_row_t stimulus_plan[$];

  int unsigned requests_accepted = 0;
  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned expiries_checked = 0;
  int unsigned group_len = 0;
  int unsigned largest_group = 0;

  function automatic request_t mk_req(mts_pkg::op_t op, logic [3:0] slot, logic [31:0] period,
                                      logic mode, logic [31:0] tag);
    request_t r;
    r.op     = op;
    r.slot   = slot;
    r.period = period;
    r.mode   = mode;
    r.tag    = tag;
    return r;
  endfunction

  function automatic result_t mk_result(mts_pkg::kind_t kind, logic [3:0] slot,
                                        logic [31:0] tag, logic [63:0] ticks, logic mode,
                                        logic last);
    result_t r;
    r.kind  = kind;
    r.slot  = slot;
    r.tag   = tag;
    r.ticks = ticks;
    r.mode  = mode;
    r.last  = last;
    return r;
  endfunction

  task automatic add_row(input request_t rq, input bit typed, input mts_pkg::kind_t kind,
                         input logic [63:0] ticks);
    stimulus_row_t row;
    row.rq    = rq;
    row.typed = typed;
    row.typed_result = mk_result(kind, (kind == mts_pkg::KIND_DONE) ? 4'd0 : rq.slot, 32'd0,
                                 ticks, 1'b0, 1'b1);
    stimulus_plan.push_back(row);
  endtask

  // Apply one request to the local timer table and list the results it causes.
  task automatic predict_timer_results(input request_t rq, output result_t outs[$]);
    outs.delete();
    case (rq.op)
      mts_pkg::OP_TICK: begin
        ticks_now = ticks_now + 64'd1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (armed[i]) begin
            if (elapsed_of[i] < period_of[i]) elapsed_of[i] = elapsed_of[i] + 32'd1;
            if (elapsed_of[i] >= period_of[i]) begin
              outs.push_back(mk_result(mts_pkg::KIND_EXPIRY, i[3:0], tag_of[i], ticks_now,
                                       repeating[i], 1'b0));
              if (repeating[i]) elapsed_of[i] = 32'd0;
              else armed[i] = 1'b0;
            end
          end
        end
        outs.push_back(mk_result(mts_pkg::KIND_DONE, 4'd0, 32'd0, ticks_now, 1'b0, 1'b1));
      end
      mts_pkg::OP_REG: begin
        if (rq.period == 32'd0) begin
          outs.push_back(mk_result(mts_pkg::KIND_REG_REJ, rq.slot, 32'd0, ticks_now,
                                   1'b0, 1'b1));
        end else begin
          armed[rq.slot]      = 1'b1;
          repeating[rq.slot]  = rq.mode;
          period_of[rq.slot]  = rq.period;
          elapsed_of[rq.slot] = 32'd0;
          tag_of[rq.slot]     = rq.tag;
          outs.push_back(mk_result(mts_pkg::KIND_REG_OK, rq.slot, 32'd0, ticks_now,
                                   1'b0, 1'b1));
        end
      end
      mts_pkg::OP_CANCEL: begin
        armed[rq.slot] = 1'b0;
        outs.push_back(mk_result(mts_pkg::KIND_CANCEL, rq.slot, 32'd0, ticks_now,
                                 1'b0, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: result_kind %0d fired_slot %0d tick_time %0d",
             rsp_ch.result_kind, rsp_ch.fired_slot, rsp_ch.tick_time);
      error_count++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("result_kind", 64'(want.kind), 64'(rsp_ch.result_kind));
    compare_field("fired_slot", 64'(want.slot), 64'(rsp_ch.fired_slot));
    compare_field("fired_tag", 64'(want.tag), 64'(rsp_ch.fired_tag));
    compare_field("tick_time", want.ticks, rsp_ch.tick_time);
    compare_field("fired_mode", 64'(want.mode), 64'(rsp_ch.fired_mode));
    compare_field("last", 64'(want.last), 64'(rsp_ch.last));
    results_checked++;
    if (want.kind == mts_pkg::KIND_EXPIRY) expiries_checked++;
    group_len++;
    if (want.last) begin
      if (group_len > largest_group) largest_group = group_len;
      group_len = 0;
    end
  endtask

  // Result side: check every transaction, stall on a rotating pattern, hold off once.
  initial begin : result_sink
    logic [15:0] pattern;
    int unsigned phase_cnt;
    int unsigned hold_left;
    bit          hold_done;
    pattern   = 16'hFFFF;
    phase_cnt = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) check_result();
      if (!hold_done && requests_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (phase_cnt % 48 == 0)
          pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
        phase_cnt++;
        rsp_ch.ready <= pattern[0];
        pattern = {pattern[0], pattern[15:1]};
      end
    end
  end

  // Abort when neither channel has moved a transaction for too long.
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no transaction for %0d cycles, %0d results outstanding", IDLE_LIMIT,
               expected_results.size());
        $display("tb_multi_timer_scheduler_unit: done, errors");
        $finish;
      end
    end
  end

  // Request side: build the plan, drive it in bursts, predict at each acceptance.
  initial begin : request_source
    stimulus_row_t row;
    result_t       outs[$];
    logic [31:0]   period_pick;
    int unsigned   burst_left, gap, idx, directed_count, counted, fills, pick, s, pause_mid;
    bit            valid_high;

    req_ch.valid        <= 1'b0;
    req_ch.operation    <= mts_pkg::OP_TICK;
    req_ch.timer_slot   <= 4'd0;
    req_ch.period_ticks <= 32'd0;
    req_ch.repeat_mode  <= 1'b0;
    req_ch.arg_tag      <= 32'd0;
    rst <= 1'b1;

    ticks_now = 64'd0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      armed[i]      = 1'b0;
      repeating[i]  = 1'b0;
      period_of[i]  = 32'd0;
      elapsed_of[i] = 32'd0;
      tag_of[i]     = 32'd0;
    end

    // Directed table: typed rows can be read straight off the spec.
    add_row(mk_req(mts_pkg::OP_TICK, 4'd0, 32'd0, 1'b0, 32'd0),
            1'b1, mts_pkg::KIND_DONE, 64'd1);
    add_row(mk_req(mts_pkg::OP_REG, 4'd0, 32'd0, 1'b1, 32'hFFFF_FFFF),
            1'b1, mts_pkg::KIND_REG_REJ, 64'd1);
    add_row(mk_req(mts_pkg::OP_CANCEL, 4'd9, 32'd0, 1'b0, 32'd0),
            1'b1, mts_pkg::KIND_CANCEL, 64'd1);
    add_row(mk_req(mts_pkg::OP_NONE, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_REG, 4'd0, 32'd1, 1'b0, 32'hFFFF_FFFF),
            1'b1, mts_pkg::KIND_REG_OK, 64'd1);
    add_row(mk_req(mts_pkg::OP_REG, 4'd15, 32'd1, 1'b1, 32'd0),
            1'b1, mts_pkg::KIND_REG_OK, 64'd1);
    add_row(mk_req(mts_pkg::OP_REG, 4'd7, 32'd2, 1'b1, 32'hA5A5_A5A5),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_TICK, 4'd0, 32'd0, 1'b0, 32'd0),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    // replace the setting of a slot that is still armed
    add_row(mk_req(mts_pkg::OP_REG, 4'd7, 32'd3, 1'b0, 32'h5A5A_5A5A),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_CANCEL, 4'd15, 32'd0, 1'b0, 32'd0),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_TICK, 4'd0, 32'd0, 1'b0, 32'd0),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_TICK, 4'd0, 32'd0, 1'b0, 32'd0),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_TICK, 4'd0, 32'd0, 1'b0, 32'd0),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_REG, 4'd3, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    // zero period on an armed slot must leave it armed
    add_row(mk_req(mts_pkg::OP_REG, 4'd3, 32'd0, 1'b0, 32'hDEAD_BEEF),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_TICK, 4'd0, 32'd0, 1'b0, 32'd0),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_CANCEL, 4'd3, 32'd0, 1'b0, 32'd0),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_CANCEL, 4'd3, 32'd0, 1'b0, 32'd0),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    add_row(mk_req(mts_pkg::OP_TICK, 4'd0, 32'd0, 1'b0, 32'd0),
            1'b0, mts_pkg::KIND_DONE, 64'd0);
    directed_count = stimulus_plan.size();

    // Random traffic, short periods so expiries come often; a few full-table fills.
    counted = 0;
    fills   = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        add_row(mk_req(mts_pkg::OP_NONE, 4'($urandom_range(0, 15)), $urandom(),
                       1'($urandom_range(0, 1)), $urandom()),
                1'b0, mts_pkg::KIND_DONE, 64'd0);
      end else if (pick < 45 || (pick >= 90 && fills >= 3)) begin
        add_row(mk_req(mts_pkg::OP_TICK, 4'($urandom_range(0, 15)), $urandom(),
                       1'($urandom_range(0, 1)), $urandom()),
                1'b0, mts_pkg::KIND_DONE, 64'd0);
        counted++;
      end else if (pick < 73) begin
        s = $urandom_range(0, 99);
        if (s < 80) period_pick = $urandom_range(1, 6);
        else if (s < 88) period_pick = 32'd0;
        else period_pick = $urandom();
        add_row(mk_req(mts_pkg::OP_REG, 4'($urandom_range(0, 15)), period_pick,
                       1'($urandom_range(0, 1)), $urandom()),
                1'b0, mts_pkg::KIND_DONE, 64'd0);
        counted++;
      end else if (pick < 90) begin
        add_row(mk_req(mts_pkg::OP_CANCEL, 4'($urandom_range(0, 15)), $urandom(),
                       1'($urandom_range(0, 1)), $urandom()),
                1'b0, mts_pkg::KIND_DONE, 64'd0);
        counted++;
      end else begin
        // arm every slot to fire on the next tick: one expiry per slot plus done
        for (int i = 0; i < SLOT_COUNT; i++)
          add_row(mk_req(mts_pkg::OP_REG, i[3:0], 32'd1, 1'($urandom_range(0, 1)),
                         $urandom()),
                  1'b0, mts_pkg::KIND_DONE, 64'd0);
        add_row(mk_req(mts_pkg::OP_TICK, 4'd0, 32'd0, 1'b0, 32'd0),
                1'b0, mts_pkg::KIND_DONE, 64'd0);
        counted += SLOT_COUNT + 1;
        fills++;
      end
    end
    pause_mid = directed_count + (stimulus_plan.size() - directed_count) / 2;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    burst_left = 0;
    valid_high = 1'b0;
    for (idx = 0; idx < stimulus_plan.size(); idx++) begin
      row = stimulus_plan[idx];
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          if (valid_high) req_ch.valid <= 1'b0;
          valid_high = 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= row.rq.op;
      req_ch.timer_slot   <= row.rq.slot;
      req_ch.period_ticks <= row.rq.period;
      req_ch.repeat_mode  <= row.rq.mode;
      req_ch.arg_tag      <= row.rq.tag;
      valid_high = 1'b1;
      do @(posedge clk); while (!req_ch.ready);
      requests_accepted <= requests_accepted + 1;
      predict_timer_results(row.rq, outs);
      if (row.typed) expected_results.push_back(row.typed_result);
      else foreach (outs[k]) expected_results.push_back(outs[k]);
      // drain completely after the directed part and once mid-run
      if (idx == directed_count - 1 || idx == pause_mid) begin
        req_ch.valid <= 1'b0;
        valid_high = 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
      end
    end
    if (valid_high) req_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d directed), %0d results checked, %0d expiries",
             requests_accepted, directed_count, results_checked, expiries_checked);
    $display("largest tick burst %0d results, %0d full-table fills, final tick count %0d",
             largest_group, fills, ticks_now);
    if (error_count == 0) begin
      $display("tb_multi_timer_scheduler_unit: done, clean");
    end else begin
      $display("tb_multi_timer_scheduler_unit: done, errors");
    end
    $finish;
  end

endmodule
